/* hw/rtl/kvrd_pkg.sv */
// Shared phase codes, default field sizes and the result record for the key/value deframer.
`default_nettype none

package kvrd_pkg;

  // Parse phases; also used as the byte role code on the output
  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_KLEN  = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_VLEN  = 3'd3;
  localparam logic [2:0] PH_VAL   = 3'd4;
  localparam logic [2:0] PH_IGN   = 3'd5;

  localparam int LENGTH_BYTES_DEF = 4;
  localparam int COUNT_BYTES_DEF  = 2;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  byte_out;
    logic [15:0] entry_number;
    logic        field_end;
    logic [31:0] field_length;
    logic        entry_done;
    logic        truncated;
    logic        stream_done;
  } kvrd_res_t;

endpackage

`default_nettype wire

/* hw/rtl/kvrd_core.sv */
// Parse state registers and the per-item tagging logic of the key/value deframer.
`default_nettype none

module kvrd_core #(
  parameter int LENGTH_BYTES = kvrd_pkg::LENGTH_BYTES_DEF,
  parameter int COUNT_BYTES  = kvrd_pkg::COUNT_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  output kvrd_pkg::kvrd_res_t     res
);
  import kvrd_pkg::*;

  localparam int MAXB  = (LENGTH_BYTES > COUNT_BYTES) ? LENGTH_BYTES : COUNT_BYTES;
  localparam int IDX_W = (MAXB > 1) ? $clog2(MAXB) : 1;
  localparam logic [IDX_W-1:0] LEN_LAST = IDX_W'(LENGTH_BYTES - 1);
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(COUNT_BYTES - 1);

  logic [2:0]       phase,         phase_next;
  logic [15:0]      entries_left,  entries_left_next;
  logic [31:0]      bytes_left,    bytes_left_next;
  logic [IDX_W-1:0] idx,           idx_next;
  logic [31:0]      acc,           acc_next;
  logic [15:0]      entry_counter, entry_counter_next;

  logic [31:0] idx32;
  logic [31:0] acc_add;
  logic [31:0] bytes_dec;
  logic [15:0] ent_dec;

  always_comb begin
    idx32     = 32'(idx);
    // bytes past the fourth of a length are consumed but not folded in
    acc_add   = (idx32 < 32'd4) ? (acc | (32'(data_byte) << {idx32[1:0], 3'b000})) : acc;
    bytes_dec = bytes_left - 32'd1;
    ent_dec   = entries_left - 16'd1;

    phase_next         = phase;
    entries_left_next  = entries_left;
    bytes_left_next    = bytes_left;
    idx_next           = idx;
    acc_next           = acc;
    entry_counter_next = entry_counter;

    res.role         = PH_IGN;
    res.byte_out     = data_byte;
    res.entry_number = 16'd0;
    res.field_end    = 1'b0;
    res.field_length = 32'd0;
    res.entry_done   = 1'b0;
    res.truncated    = 1'b0;
    res.stream_done  = last_byte;

    case (phase)
      PH_COUNT: begin
        res.role = PH_COUNT;
        if (idx == CNT_LAST) begin
          idx_next           = '0;
          acc_next           = 32'd0;
          res.field_end      = 1'b1;
          res.field_length   = acc_add;
          entries_left_next  = acc_add[15:0];
          entry_counter_next = 16'd0;
          phase_next         = (acc_add[15:0] == 16'd0) ? PH_IGN : PH_KLEN;
        end else begin
          idx_next = idx + 1'b1;
          acc_next = acc_add;
        end
      end
      PH_KLEN, PH_VLEN: begin
        res.role         = phase;
        res.entry_number = entry_counter;
        if (idx == LEN_LAST) begin
          idx_next         = '0;
          acc_next         = 32'd0;
          res.field_end    = 1'b1;
          res.field_length = acc_add;
          bytes_left_next  = acc_add;
          if (phase == PH_KLEN) begin
            // empty key goes straight to the value length
            phase_next = (acc_add == 32'd0) ? PH_VLEN : PH_KEY;
          end else if (acc_add == 32'd0) begin
            res.entry_done     = 1'b1;
            entry_counter_next = entry_counter + 16'd1;
            entries_left_next  = ent_dec;
            phase_next         = (ent_dec == 16'd0) ? PH_IGN : PH_KLEN;
          end else begin
            phase_next = PH_VAL;
          end
        end else begin
          idx_next = idx + 1'b1;
          acc_next = acc_add;
        end
      end
      PH_KEY, PH_VAL: begin
        res.role         = phase;
        res.entry_number = entry_counter;
        bytes_left_next  = bytes_dec;
        if (bytes_dec == 32'd0) begin
          res.field_end = 1'b1;
          if (phase == PH_KEY) begin
            phase_next = PH_VLEN;
          end else begin
            res.entry_done     = 1'b1;
            entry_counter_next = entry_counter + 16'd1;
            entries_left_next  = ent_dec;
            phase_next         = (ent_dec == 16'd0) ? PH_IGN : PH_KLEN;
          end
        end
      end
      default: begin
        res.role   = PH_IGN;
        phase_next = PH_IGN;
      end
    endcase

    if (last_byte) begin
      // ended inside the count or an entry; a clean entry boundary is not truncation
      res.truncated = (phase_next == PH_COUNT) || (phase_next == PH_KEY) ||
                      (phase_next == PH_VLEN) || (phase_next == PH_VAL) ||
                      ((phase_next == PH_KLEN) && (idx_next != '0));
      phase_next         = PH_COUNT;
      entries_left_next  = 16'd0;
      bytes_left_next    = 32'd0;
      idx_next           = '0;
      acc_next           = 32'd0;
      entry_counter_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COUNT;
      entries_left  <= 16'd0;
      bytes_left    <= 32'd0;
      idx           <= '0;
      acc           <= 32'd0;
      entry_counter <= 16'd0;
    end else if (step) begin
      phase         <= phase_next;
      entries_left  <= entries_left_next;
      bytes_left    <= bytes_left_next;
      idx           <= idx_next;
      acc           <= acc_next;
      entry_counter <= entry_counter_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/key_value_record_deframer.sv */
// Top level of the key/value record deframer: input register, parser and result register.
//
// Usage:
//   Slave channel (s_*) carries the serialized buffer one byte per item;
//   s_tlast marks the buffer's final byte. Master channel (m_*) returns one
//   tagged item per input byte, in order: the role code on m_tuser, the byte,
//   entry index, field end, assembled length, entry done and truncation flags
//   on m_tdata, and m_tlast on the item of the buffer's last byte.
// Path: an accepted byte is held in the input register, parsed by the core,
//   and its item is written to the result register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready is high; the parse step is a
//   single compare/decrement on the phase and counters, so nothing iterates.
// Stalls: when m_tready is low the result register holds, the input register
//   fills and then s_tready drops; no item is lost or repeated, and full rate
//   resumes the cycle m_tready returns.
// Reset: rst (synchronous) empties both registers and returns the parser to
//   the entry count. After each item with s_tlast the parser also returns to
//   the entry count, ready for the next buffer.
`default_nettype none

module key_value_record_deframer #(
  parameter int LENGTH_BYTES = kvrd_pkg::LENGTH_BYTES_DEF,
  parameter int COUNT_BYTES  = kvrd_pkg::COUNT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  // tagged output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [7:0] byte_out, [23:8] entry_number, [24] field_end,
                                      // [56:25] field_length, [57] entry_done,
                                      // [58] truncated, [63:59] zero
  output logic [2:0]       m_tuser,   // [2:0] byte_role
  output logic             m_tlast    // stream_done
);
  import kvrd_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // result register
  logic      out_valid;
  kvrd_res_t out_res;
  kvrd_res_t res;

  logic advance;

  // item moves from input register through the parser into the result register
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  kvrd_core #(
    .LENGTH_BYTES (LENGTH_BYTES),
    .COUNT_BYTES  (COUNT_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_data),
    .last_byte (in_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.role;
  assign m_tlast  = out_res.stream_done;
  assign m_tdata  = {5'd0, out_res.truncated, out_res.entry_done, out_res.field_length,
                     out_res.field_end, out_res.entry_number, out_res.byte_out};

endmodule

`default_nettype wire

/* tb/key_value_record_deframer_tb.sv */
// Self-checking testbench for the key/value record deframer: directed buffers, then random ones.
`default_nettype none

module key_value_record_deframer_tb;
  import kvrd_pkg::*;

  // one item of the input stream; typed rows carry a hand-written expectation
  typedef struct {
    logic [7:0] data;
    logic       lst;
    bit         typed;
    kvrd_res_t  tag;
  } buf_byte_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  key_value_record_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  buf_byte_t  buffer_bytes[$];   // whole input stream, built during reset
  kvrd_res_t  pending_tags[$];   // tags still owed by the block, oldest first
  logic [7:0] frame_q[$];        // scratch for one random buffer

  // parser state of the predictor
  logic [2:0]  ph;
  logic [15:0] entries_left;
  logic [31:0] bytes_left;
  int          len_idx;
  logic [31:0] len_acc;
  logic [15:0] entry_cnt;

  int n_errors;
  int n_accepted;
  int n_checked;
  int n_buffers;
  int n_entries;
  int n_trunc;
  int n_ignored;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic kvrd_res_t mk_tag(logic [2:0] role, logic [7:0] b, logic [15:0] ent,
                                       logic fend, logic [31:0] flen, logic edone,
                                       logic trunc, logic sd);
    kvrd_res_t r;
    r.role         = role;
    r.byte_out     = b;
    r.entry_number = ent;
    r.field_end    = fend;
    r.field_length = flen;
    r.entry_done   = edone;
    r.truncated    = trunc;
    r.stream_done  = sd;
    return r;
  endfunction

  function automatic void add_byte(logic [7:0] d, logic l, bit t = 1'b0,
                                   kvrd_res_t e = '0);
    buf_byte_t it;
    it.data  = d;
    it.lst   = l;
    it.typed = t;
    it.tag   = e;
    buffer_bytes = {buffer_bytes, it};
  endfunction

  // little-endian field into the scratch buffer
  function automatic void push_le(logic [31:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) frame_q = {frame_q, v[8*i +: 8]};
  endfunction

  // one random byte onto the scratch buffer
  function automatic void add_rand_byte();
    logic [7:0] rb;
    rb      = 8'($urandom_range(0, 255));
    frame_q = {frame_q, rb};
  endfunction

  function automatic void restart_parse();
    ph           = PH_COUNT;
    entries_left = '0;
    bytes_left   = '0;
    len_idx      = 0;
    len_acc      = '0;
    entry_cnt    = '0;
  endfunction

  // one byte into the length accumulator; 1 when the n-byte field is complete
  function automatic bit take_len_byte(logic [7:0] b, int n);
    if (len_idx < 4) len_acc = len_acc | (32'(b) << (8 * len_idx));
    if (len_idx + 1 >= n) begin
      len_idx = 0;
      return 1'b1;
    end
    len_idx++;
    return 1'b0;
  endfunction

  function automatic void close_entry();
    entry_cnt    = entry_cnt + 16'd1;
    entries_left = entries_left - 16'd1;
    ph           = (entries_left == 16'd0) ? PH_IGN : PH_KLEN;
  endfunction

  // tag that the block owes for one input byte; advances the parser state
  function automatic kvrd_res_t parse_byte(logic [7:0] b, logic lst);
    kvrd_res_t   r;
    logic [31:0] len;
    r             = '0;
    r.role        = PH_IGN;
    r.byte_out    = b;
    r.stream_done = lst;
    case (ph)
      PH_COUNT: begin
        r.role = PH_COUNT;
        if (take_len_byte(b, COUNT_BYTES_DEF)) begin
          len            = len_acc;
          len_acc        = '0;
          r.field_end    = 1'b1;
          r.field_length = len;
          entries_left   = len[15:0];
          entry_cnt      = '0;
          ph             = (entries_left == 16'd0) ? PH_IGN : PH_KLEN;
        end
      end
      PH_KLEN, PH_VLEN: begin
        r.role         = ph;
        r.entry_number = entry_cnt;
        if (take_len_byte(b, LENGTH_BYTES_DEF)) begin
          len            = len_acc;
          len_acc        = '0;
          r.field_end    = 1'b1;
          r.field_length = len;
          bytes_left     = len;
          if (ph == PH_KLEN) begin
            ph = (len == 32'd0) ? PH_VLEN : PH_KEY;
          end else if (len == 32'd0) begin
            r.entry_done = 1'b1;
            close_entry();
          end else begin
            ph = PH_VAL;
          end
        end
      end
      PH_KEY, PH_VAL: begin
        r.role         = ph;
        r.entry_number = entry_cnt;
        bytes_left     = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          r.field_end = 1'b1;
          if (ph == PH_KEY) begin
            ph = PH_VLEN;
          end else begin
            r.entry_done = 1'b1;
            close_entry();
          end
        end
      end
      default: begin
        r.role = PH_IGN;
        ph     = PH_IGN;
      end
    endcase
    if (lst) begin
      // ending inside the count, a field or an entry is a truncated buffer
      if (ph == PH_COUNT || ph == PH_KEY || ph == PH_VLEN || ph == PH_VAL ||
          (ph == PH_KLEN && len_idx != 0))
        r.truncated = 1'b1;
      restart_parse();
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch on result %0d, %s: got %0h, expected %0h",
               n_checked, field, got, want);
  endtask

  // accept input items into the predictor, check output items against it
  always @(posedge clk) begin
    kvrd_res_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        e = parse_byte(s_tdata, s_tlast);
        if (n_accepted < buffer_bytes.size() && buffer_bytes[n_accepted].typed)
          e = buffer_bytes[n_accepted].tag;
        pending_tags = {pending_tags, e};
        n_accepted++;
        n_buffers += e.stream_done;
        n_entries += e.entry_done;
        n_trunc   += e.truncated;
        n_ignored += (e.role == PH_IGN);
      end
      if (m_tvalid && m_tready) begin
        if (pending_tags.size() == 0) begin
          report_mismatch("unexpected item", m_tdata[31:0], '0);
        end else begin
          e = pending_tags.pop_front();
          if (m_tuser !== e.role)              report_mismatch("byte_role", m_tuser, e.role);
          if (m_tdata[7:0] !== e.byte_out)     report_mismatch("byte_out", m_tdata[7:0],
                                                               e.byte_out);
          if (m_tdata[23:8] !== e.entry_number) report_mismatch("entry_number", m_tdata[23:8],
                                                                e.entry_number);
          if (m_tdata[24] !== e.field_end)     report_mismatch("field_end", m_tdata[24],
                                                               e.field_end);
          if (m_tdata[56:25] !== e.field_length) report_mismatch("field_length",
                                                                 m_tdata[56:25],
                                                                 e.field_length);
          if (m_tdata[57] !== e.entry_done)    report_mismatch("entry_done", m_tdata[57],
                                                               e.entry_done);
          if (m_tdata[58] !== e.truncated)     report_mismatch("truncated", m_tdata[58],
                                                               e.truncated);
          if (m_tdata[63:59] !== 5'd0)         report_mismatch("pad bits", m_tdata[63:59], '0);
          if (m_tlast !== e.stream_done)       report_mismatch("stream_done", m_tlast,
                                                               e.stream_done);
        end
        n_checked++;
      end
    end
  end

  // receiver: free-running, random, or on/off runs, switching every so often
  int rx_mode;
  int rx_left;
  int rx_run;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 150);
    end
    rx_left--;
    case (rx_mode)
      0: m_tready = 1'b1;
      1: m_tready = $urandom_range(0, 1);
      default: begin
        if (rx_run == 0) begin
          m_tready = ~m_tready;
          rx_run   = $urandom_range(1, 8);
        end
        rx_run--;
      end
    endcase
  end

  initial begin
    #3000000;
    $display("timeout: %0d of %0d items accepted, %0d tags outstanding",
             n_accepted, buffer_bytes.size(), pending_tags.size());
    $display("** key_value_record_deframer: FAILED **");
    $finish;
  end

  initial begin
    int n_ent;
    int kl;
    int vl;
    int kind;
    int cut;
    int extra;
    int burst_left;
    int gap;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    rx_mode  = 0;
    rx_left  = 0;
    rx_run   = 0;
    n_errors = 0; n_accepted = 0; n_checked = 0;
    n_buffers = 0; n_entries = 0; n_trunc = 0; n_ignored = 0;
    restart_parse();

    // --- directed buffers ---
    // zero count, then one trailing byte that is ignored
    add_byte(8'h00, 1'b0, 1'b1, mk_tag(PH_COUNT, 8'h00, 0, 0, 0, 0, 0, 0));
    add_byte(8'h00, 1'b0, 1'b1, mk_tag(PH_COUNT, 8'h00, 0, 1, 0, 0, 0, 0));
    add_byte(8'hFF, 1'b1, 1'b1, mk_tag(PH_IGN, 8'hFF, 0, 0, 0, 0, 0, 1));
    // buffer shorter than the count
    add_byte(8'hFF, 1'b1, 1'b1, mk_tag(PH_COUNT, 8'hFF, 0, 0, 0, 0, 1, 1));
    // one entry, zero key and zero value length, ending at the entry boundary
    add_byte(8'h01, 1'b0, 1'b1, mk_tag(PH_COUNT, 8'h01, 0, 0, 0, 0, 0, 0));
    add_byte(8'h00, 1'b0, 1'b1, mk_tag(PH_COUNT, 8'h00, 0, 1, 1, 0, 0, 0));
    for (int i = 0; i < 7; i++) add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1, 1'b1, mk_tag(PH_VLEN, 8'h00, 0, 1, 0, 1, 0, 1));
    // maximum count, one-byte key, buffer ends on the key
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b1, mk_tag(PH_COUNT, 8'hFF, 0, 1, 32'hFFFF, 0, 0, 0));
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hAB, 1'b1, 1'b1, mk_tag(PH_KEY, 8'hAB, 0, 1, 0, 0, 1, 1));

    // --- random buffers: mostly well formed, some cut short, some noise ---
    while (buffer_bytes.size() < 430) begin
      frame_q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8)) add_rand_byte();
      end else begin
        n_ent = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        push_le(n_ent, COUNT_BYTES_DEF);
        for (int e = 0; e < n_ent; e++) begin
          kl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          push_le(kl, LENGTH_BYTES_DEF);
          repeat (kl) add_rand_byte();
          vl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          push_le(vl, LENGTH_BYTES_DEF);
          repeat (vl) add_rand_byte();
        end
        if (kind <= 2 && frame_q.size() > 1) begin
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end else begin
          extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
          repeat (extra) add_rand_byte();
        end
      end
      foreach (frame_q[i]) add_byte(frame_q[i], i == frame_q.size() - 1);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender: bursts of random length with random gaps, some stretches gap-free
    burst_left = 0;
    foreach (buffer_bytes[i]) begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ((i / 80) % 3 != 1) gap = $urandom_range(0, 6);
      end
      burst_left--;
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata  = $urandom_range(0, 255);
        s_tlast  = $urandom_range(0, 1);
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      s_tvalid = 1'b1;
      s_tdata  = buffer_bytes[i].data;
      s_tlast  = buffer_bytes[i].lst;
      do @(posedge clk); while (!s_tready);
    end
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;

    while (pending_tags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items in %0d buffers: %0d entries completed, %0d truncated ends,",
             n_accepted, n_buffers, n_entries, n_trunc);
    $display("%0d ignored items, %0d tagged items checked, %0d mismatches",
             n_ignored, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("** key_value_record_deframer: PASSED **");
    end else begin
      $display("** key_value_record_deframer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
